// File: hdl/hmsct_pkg.sv
// package for the hours/minutes/seconds countdown alarm timer
// holds field widths, reset values, command and button codes
// no dependencies
package hmsct_pkg;

  // field widths
  localparam int TPS_W   = 16;
  localparam int HOUR_W  = 7;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int BTN_W   = 4;

  // packed stream widths, tdata in whole bytes
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 24;

  // defaults and limits
  localparam int              HOURS_LIMIT_DEF = 100;
  localparam logic [TPS_W-1:0] TPS_RESET      = 16'd15;
  localparam logic [SEC_W-1:0] SEC_MAX        = 6'd59;
  localparam logic [MIN_W-1:0] MIN_MAX        = 6'd59;

  // request kind carried in tuser
  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_BUTTON = 1'b1;

  // button bit positions, lowest set bit wins
  localparam int BTN_RUN  = 0;
  localparam int BTN_SEC  = 1;
  localparam int BTN_MIN  = 2;
  localparam int BTN_HOUR = 3;

endpackage

// File: hdl/hms_countdown_alarm_timer_unit.sv
// countdown timer in hours, minutes and seconds with a latched alarm
// a request passes through the input register and then the result register
// throughput: one request per cycle, limited only by the result channel's tready
// every request yields exactly one result showing the state after the update
// reset (rst_n low, synchronous): time 0:0:0, stopped, alarm off, prescaler 0,
// ticks_per_second back to 15, both pipeline stages empty
module hms_countdown_alarm_timer_unit #(
  parameter int HOURS_LIMIT = hmsct_pkg::HOURS_LIMIT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration: ticks_per_second
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hmsct_pkg::TPS_W-1:0]        cfg_data,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [hmsct_pkg::IN_TDATA_W-1:0]   in_tdata,   // [3:0] buttons, [7:4] zero
  input  logic [hmsct_pkg::IN_TUSER_W-1:0]   in_tuser,   // [0] cmd
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [hmsct_pkg::OUT_TDATA_W-1:0]  out_tdata   // [6:0] hours, [12:7] minutes,
                                                         // [18:13] seconds, [19] running,
                                                         // [20] alarm, [23:21] zero
);
  import hmsct_pkg::*;

  // configuration register
  logic [TPS_W-1:0] tps_r;

  // input stage
  logic             s1_valid_r;
  logic             s1_cmd_r;
  logic [BTN_W-1:0] s1_btn_r;

  // timer state
  logic [TPS_W-1:0]  presc_r, presc_nxt;
  logic [HOUR_W-1:0] hour_r, hour_nxt;
  logic [MIN_W-1:0]  min_r, min_nxt;
  logic [SEC_W-1:0]  sec_r, sec_nxt;
  logic              run_r, run_nxt;
  logic              alarm_r, alarm_nxt;

  // result stage
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // handshake and stage advance
  logic out_free;
  logic s1_adv;
  logic in_acc;

  // helper values
  logic [TPS_W:0]    presc_inc;
  logic [HOUR_W:0]   hour_inc;
  logic              time_zero;

  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid_r || out_tready;
  assign s1_adv     = s1_valid_r && out_free;
  assign in_tready  = !s1_valid_r || out_free;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign presc_inc = {1'b0, presc_r} + {{TPS_W{1'b0}}, 1'b1};
  assign hour_inc  = {1'b0, hour_r} + {{HOUR_W{1'b0}}, 1'b1};
  assign time_zero = (hour_r == '0) && (min_r == '0) && (sec_r == '0);

  // state update for the request in the input stage
  always_comb begin
    presc_nxt = presc_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    run_nxt   = run_r;
    alarm_nxt = alarm_r;
    if (s1_cmd_r == CMD_TICK) begin
      if (run_r) begin
        if (presc_inc >= {1'b0, tps_r}) begin
          // one second elapses: at zero stop and raise the alarm, else decrement with borrow
          presc_nxt = '0;
          if (time_zero) begin
            run_nxt   = 1'b0;
            alarm_nxt = 1'b1;
          end else if (sec_r != '0) begin
            sec_nxt = sec_r - 1'b1;
          end else if (min_r != '0) begin
            sec_nxt = SEC_MAX;
            min_nxt = min_r - 1'b1;
          end else begin
            sec_nxt  = SEC_MAX;
            min_nxt  = MIN_MAX;
            hour_nxt = hour_r - 1'b1;
          end
        end else begin
          presc_nxt = presc_inc[TPS_W-1:0];
        end
      end
    end else begin
      // button event, lowest set bit acts
      if (s1_btn_r[BTN_RUN]) begin
        run_nxt = !run_r;
      end else if (s1_btn_r[BTN_SEC]) begin
        sec_nxt = (sec_r >= SEC_MAX) ? '0 : sec_r + 1'b1;
      end else if (s1_btn_r[BTN_MIN]) begin
        min_nxt = (min_r >= MIN_MAX) ? '0 : min_r + 1'b1;
      end else if (s1_btn_r[BTN_HOUR]) begin
        hour_nxt = (hour_inc >= (HOUR_W+1)'(HOURS_LIMIT)) ? '0 : hour_inc[HOUR_W-1:0];
      end
    end
  end

  // result packing
  always_comb begin
    out_data_nxt = {3'b000, alarm_nxt, run_nxt, sec_nxt, min_nxt, hour_nxt};
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tps_r <= cfg_data;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r <= in_tuser[0];
      s1_btn_r <= in_tdata[BTN_W-1:0];
    end
  end

  // timer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      presc_r <= '0;
      hour_r  <= '0;
      min_r   <= '0;
      sec_r   <= '0;
      run_r   <= 1'b0;
      alarm_r <= 1'b0;
    end else if (s1_adv) begin
      presc_r <= presc_nxt;
      hour_r  <= hour_nxt;
      min_r   <= min_nxt;
      sec_r   <= sec_nxt;
      run_r   <= run_nxt;
      alarm_r <= alarm_nxt;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  // alarm latches until reset
  a_alarm_latched: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(alarm_r)) |-> alarm_r)
    else $error("alarm cleared without reset");

  // expiry stops the count at zero
  a_expiry_stops: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(alarm_r) |-> (!run_r && hour_r == '0 && min_r == '0 && sec_r == '0))
    else $error("alarm raised while running or with time left");

  // time fields stay in range
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sec_r <= SEC_MAX) && (min_r <= MIN_MAX) && ({1'b0, hour_r} < (HOUR_W+1)'(HOURS_LIMIT)))
    else $error("time field out of range");

  // state only moves when a request leaves the input stage
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(s1_adv)) |-> ($stable(sec_r) && $stable(run_r) && $stable(presc_r)))
    else $error("timer state changed without a request");

endmodule
